/* design/ptw_pkg.sv */
// Shared types and constants for the page table map and walk block.
// Used by ptw_ctrl, ptw_datapath and page_table_map_and_walk.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int ENTRY_W  = 64;
    localparam int IDX_W    = 9;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int PG_OFF_W = 12;
    localparam int FRAME_W  = ENTRY_W - PG_OFF_W;

    localparam int SHIFT_PML4 = 39;
    localparam int SHIFT_PDPT = 30;
    localparam int SHIFT_PD   = 21;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;

    localparam logic [ENTRY_W-1:0] FLAG_PRESENT  = 64'h1;
    localparam logic [ENTRY_W-1:0] FLAG_WRITABLE = 64'h2;
    localparam logic [ENTRY_W-1:0] FLAG_LARGE    = 64'h80;
    localparam logic [ENTRY_W-1:0] LINK_FLAGS    = FLAG_PRESENT | FLAG_WRITABLE;
    localparam logic [ENTRY_W-1:0] LEAF_FLAGS    = LINK_FLAGS | FLAG_LARGE;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ROOT_NEW,
        CMD_ROOT_USE,
        CMD_READ,
        CMD_LINK_NEW,
        CMD_LINK_ZERO,
        CMD_LINK_OLD,
        CMD_DESCEND,
        CMD_CLEAR,
        CMD_LEAF,
        CMD_RESULT
    } ptw_cmd_code_t;

    typedef struct packed {
        ptw_cmd_code_t code;
        logic [1:0]    res;
    } ptw_cmd_t;

    typedef struct packed {
        logic op;
        logic root_valid;
        logic pool_full;
        logic present;
        logic in_pool;
        logic lvl_last;
        logic clr_last;
        logic out_free;
    } ptw_sts_t;

endpackage

/* design/page_table_map_and_walk.sv */
// Three-level page table map/translate block with 2 MB leaves and local table pool.
// Each table allocated is cleared before use, one page entry a cycle. Only one item is
// in flight: the next item can be accepted from the cycle the result shows, and an output
// stall holds the walk in its finish state until the output register is free.
// Sync reset empties tree and allocator, zeroes pool base; table memory not cleared.
`timescale 1ns / 1ps

module page_table_map_and_walk
    import ptw_pkg::*;
#(
    parameter int POOL_PAGES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [PA_W-1:0]    cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [VA_W-1:0]    s_virt_addr,
    input  logic [PA_W-1:0]    s_phys_addr,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [ENTRY_W-1:0] m_translated_entry
);

    ptw_cmd_t cmd;
    ptw_sts_t sts;

    ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptw_datapath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_opcode           (s_opcode),
        .s_virt_addr        (s_virt_addr),
        .s_phys_addr        (s_phys_addr),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_translated_entry (m_translated_entry),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

/* design/ptw_ctrl.sv */
// Sequencer for map and translate walks: issues at most one datapath command a cycle.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ptw_sts_t sts,
    output ptw_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CLEAR,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.code   = CMD_NONE;
        cmd.res    = res_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.code   = CMD_LOAD;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (!sts.root_valid) begin
                    if (sts.op == OP_XLATE) begin
                        res_next   = ST_UNMAPPED;
                        state_next = ST_FINISH;
                    end else if (sts.pool_full) begin
                        res_next   = ST_OOM;
                        state_next = ST_FINISH;
                    end else begin
                        cmd.code   = CMD_ROOT_NEW;
                        state_next = ST_CLEAR;
                    end
                end else begin
                    cmd.code   = CMD_ROOT_USE;
                    state_next = ST_READ;
                end
            end
            ST_CLEAR: begin
                cmd.code = CMD_CLEAR;
                if (sts.clr_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // map writes the leaf blind, no read needed
                if (sts.op == OP_MAP && sts.lvl_last) begin
                    cmd.code   = CMD_LEAF;
                    res_next   = ST_OK;
                    state_next = ST_FINISH;
                end else begin
                    cmd.code   = CMD_READ;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.op == OP_XLATE) begin
                    if (sts.lvl_last) begin
                        res_next   = sts.present ? ST_OK : ST_UNMAPPED;
                        state_next = ST_FINISH;
                    end else if (!sts.present || !sts.in_pool) begin
                        res_next   = ST_UNMAPPED;
                        state_next = ST_FINISH;
                    end else begin
                        cmd.code   = CMD_DESCEND;
                        state_next = ST_READ;
                    end
                end else if (!sts.present) begin
                    if (sts.pool_full) begin
                        cmd.code   = CMD_LINK_ZERO;
                        res_next   = ST_OOM;
                        state_next = ST_FINISH;
                    end else begin
                        cmd.code   = CMD_LINK_NEW;
                        state_next = ST_CLEAR;
                    end
                end else if (!sts.in_pool) begin
                    res_next   = ST_OOM;
                    state_next = ST_FINISH;
                end else begin
                    cmd.code   = CMD_LINK_OLD;
                    state_next = ST_READ;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.code   = CMD_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            res_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    a_result_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.code == CMD_RESULT |-> sts.out_free)
        else $error("result issued while output register busy");

    a_clear_ends_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR && sts.clr_last |=> state_reg == ST_READ)
        else $error("page clear did not return to walk");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_START)
        else $error("accepted item did not start a walk");

endmodule

/* design/ptw_datapath.sv */
// Walk datapath: table memory, allocator, walk pointer and result register.
// Depends on ptw_pkg; driven by commands from ptw_ctrl.
`timescale 1ns / 1ps

module ptw_datapath
    import ptw_pkg::*;
#(
    parameter int POOL_PAGES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [PA_W-1:0]    cfg_wr_data,
    input  logic               s_opcode,
    input  logic [VA_W-1:0]    s_virt_addr,
    input  logic [PA_W-1:0]    s_phys_addr,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [ENTRY_W-1:0] m_translated_entry,
    input  ptw_cmd_t           cmd,
    output ptw_sts_t           sts
);

    localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int CNT_W  = $clog2(POOL_PAGES + 1);
    localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_TABLE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ENTRY_W-1:0] table_mem [DEPTH];

    logic               op_reg, op_next;
    logic [VA_W-1:0]    va_reg, va_next;
    logic [PA_W-1:0]    pa_reg, pa_next;
    logic [PA_W-1:0]    base_reg, base_next;
    logic [PAGE_W-1:0]  cur_reg, cur_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [CNT_W-1:0]   next_free_reg, next_free_next;
    logic               root_valid_reg, root_valid_next;
    logic [PAGE_W-1:0]  root_page_reg, root_page_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [ENTRY_W-1:0] m_entry_reg, m_entry_next;

    logic [IDX_W-1:0]   idx;
    logic [ADDR_W-1:0]  slot_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data, link_new;
    logic               mem_we, mem_re;
    logic [FRAME_W-1:0] frame_diff;
    logic               in_pool, pool_full;
    logic [PAGE_W-1:0]  nf_page, entry_page;

    always_comb begin
        case (lvl_reg)
            LVL_PML4: idx = va_reg[SHIFT_PML4 +: IDX_W];
            LVL_PDPT: idx = va_reg[SHIFT_PDPT +: IDX_W];
            default:  idx = va_reg[SHIFT_PD +: IDX_W];
        endcase
    end

    assign slot_addr = ADDR_W'({cur_reg, idx});
    assign pool_full = next_free_reg >= CNT_W'(POOL_PAGES);
    assign nf_page   = next_free_reg[PAGE_W-1:0];

    // entry address of pool page next_free: aligned base + page * 4 KB
    assign link_new = {FRAME_W'(base_reg[PA_W-1:PG_OFF_W]) + FRAME_W'(next_free_reg),
                       {PG_OFF_W{1'b0}}} | LINK_FLAGS;

    // page number named by an entry, relative to the pool base (wraps like 64-bit math)
    assign frame_diff = rdata_reg[ENTRY_W-1:PG_OFF_W] - FRAME_W'(base_reg[PA_W-1:PG_OFF_W]);
    assign in_pool    = frame_diff < FRAME_W'(POOL_PAGES);
    assign entry_page = frame_diff[PAGE_W-1:0];

    always_comb begin
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = slot_addr;
        wr_data = '0;
        case (cmd.code)
            CMD_READ:      mem_re = 1'b1;
            CMD_LINK_NEW: begin
                mem_we  = 1'b1;
                wr_data = link_new;
            end
            CMD_LINK_ZERO: mem_we = 1'b1;
            CMD_LINK_OLD: begin
                mem_we  = 1'b1;
                wr_data = rdata_reg | LINK_FLAGS;
            end
            CMD_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = ADDR_W'({cur_reg, clr_cnt_reg});
            end
            CMD_LEAF: begin
                mem_we  = 1'b1;
                wr_data = {{(ENTRY_W - PA_W){1'b0}}, pa_reg} | LEAF_FLAGS;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            rdata_reg <= table_mem[slot_addr];
        end
    end

    always_comb begin
        op_next         = op_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        base_next       = cfg_wr_en ? cfg_wr_data : base_reg;
        cur_next        = cur_reg;
        lvl_next        = lvl_reg;
        next_free_next  = next_free_reg;
        root_valid_next = root_valid_reg;
        root_page_next  = root_page_reg;
        clr_cnt_next    = clr_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_entry_next    = m_entry_reg;
        case (cmd.code)
            CMD_LOAD: begin
                op_next  = s_opcode;
                va_next  = s_virt_addr;
                pa_next  = s_phys_addr;
                lvl_next = LVL_PML4;
            end
            CMD_ROOT_NEW: begin
                root_valid_next = 1'b1;
                root_page_next  = nf_page;
                cur_next        = nf_page;
                next_free_next  = next_free_reg + 1'b1;
                clr_cnt_next    = '0;
            end
            CMD_ROOT_USE: cur_next = root_page_reg;
            CMD_LINK_NEW: begin
                cur_next       = nf_page;
                next_free_next = next_free_reg + 1'b1;
                clr_cnt_next   = '0;
                lvl_next       = lvl_reg + 1'b1;
            end
            CMD_LINK_OLD, CMD_DESCEND: begin
                cur_next = entry_page;
                lvl_next = lvl_reg + 1'b1;
            end
            CMD_CLEAR: clr_cnt_next = clr_cnt_reg + 1'b1;
            CMD_RESULT: begin
                m_valid_next  = 1'b1;
                m_status_next = cmd.res;
                m_entry_next  = (cmd.res == ST_OK && op_reg == OP_XLATE) ?
                                {rdata_reg[ENTRY_W-1:PG_OFF_W], {PG_OFF_W{1'b0}}} : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            next_free_reg  <= '0;
            root_valid_reg <= 1'b0;
            root_page_reg  <= '0;
            lvl_reg        <= LVL_PML4;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            base_reg       <= base_next;
            next_free_reg  <= next_free_next;
            root_valid_reg <= root_valid_next;
            root_page_reg  <= root_page_next;
            lvl_reg        <= lvl_next;
            clr_cnt_reg    <= clr_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg       <= op_next;
        va_reg       <= va_next;
        pa_reg       <= pa_next;
        cur_reg      <= cur_next;
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_translated_entry = m_entry_reg;

    assign sts.op         = op_reg;
    assign sts.root_valid = root_valid_reg;
    assign sts.pool_full  = pool_full;
    assign sts.present    = rdata_reg[0];
    assign sts.in_pool    = in_pool;
    assign sts.lvl_last   = lvl_reg == LVL_PD;
    assign sts.clr_last   = clr_cnt_reg == IDX_W'(ENTRIES_PER_TABLE - 1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    a_alloc_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= CNT_W'(POOL_PAGES))
        else $error("allocator ran past the pool");

    a_root_alloc_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.code == CMD_ROOT_NEW |-> !root_valid_reg && !pool_full)
        else $error("root allocated twice or from a full pool");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.code == CMD_RESULT |=> m_valid_reg)
        else $error("result item not presented");

endmodule

/* dv/tb_top.sv */
// Self-checking bench for page_table_map_and_walk: map and translate items against an
// in-bench table pool model, with four pool base settings and random stalls on both sides.
// Depends on ptw_pkg and the page_table_map_and_walk RTL.
`timescale 1ns / 1ps

module tb_top;
    import ptw_pkg::*;

    localparam int POOL_PAGES = 32;
    localparam int PAGE_ENTRIES = ENTRIES_PER_TABLE;
    localparam logic [ENTRY_W-1:0] OFF_MASK = 64'hfff;
    localparam logic [PA_W-1:0] BASE_TOP = 52'hf_ffff_ffff_f000;

    typedef struct packed {
        logic            op;
        logic [VA_W-1:0] va;
        logic [PA_W-1:0] pa;
    } walk_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] entry;
    } walk_rsp_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [PA_W-1:0]    cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = OP_MAP;
    logic [VA_W-1:0]    s_virt_addr = '0;
    logic [PA_W-1:0]    s_phys_addr = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [ENTRY_W-1:0] m_translated_entry;

    page_table_map_and_walk #(.POOL_PAGES(POOL_PAGES)) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_virt_addr        (s_virt_addr),
        .s_phys_addr        (s_phys_addr),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_translated_entry (m_translated_entry)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ---- table pool model ----
    logic [ENTRY_W-1:0] pt_mem [POOL_PAGES*PAGE_ENTRIES];
    bit                 root_ok = 1'b0;
    int unsigned        root_pg = 0;
    int unsigned        free_pg = 0;
    logic [PA_W-1:0]    pool_base = '0;

    function automatic logic [ENTRY_W-1:0] base_frame();
        return {12'h0, pool_base[PA_W-1:PG_OFF_W], 12'h0};
    endfunction

    function automatic logic [ENTRY_W-1:0] page_frame(int unsigned pg);
        return base_frame() + (ENTRY_W'(pg) << PG_OFF_W);
    endfunction

    // false when the pointer names no pool page under the current base
    function automatic bit frame_to_page(logic [ENTRY_W-1:0] e, output int unsigned pg);
        logic [ENTRY_W-1:0] off;
        off = ((e & ~OFF_MASK) - base_frame()) >> PG_OFF_W;
        if (off >= POOL_PAGES)
            return 1'b0;
        pg = off[31:0];
        return 1'b1;
    endfunction

    function automatic bit grab_page(output int unsigned pg);
        int i;
        if (free_pg >= POOL_PAGES)
            return 1'b0;
        pg = free_pg;
        free_pg++;
        for (i = 0; i < PAGE_ENTRIES; i++)
            pt_mem[pg*PAGE_ENTRIES + i] = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned entry_slot(int unsigned pg, logic [VA_W-1:0] va, int sh);
        return pg*PAGE_ENTRIES + va[sh +: IDX_W];
    endfunction

    function automatic logic [1:0] map_leaf(logic [VA_W-1:0] va, logic [PA_W-1:0] pa);
        int unsigned cur;
        int unsigned nxt;
        int unsigned s;
        int lvl;
        if (!root_ok) begin
            if (!grab_page(cur))
                return ST_OOM;
            root_ok = 1'b1;
            root_pg = cur;
        end
        cur = root_pg;
        for (lvl = 0; lvl < 2; lvl++) begin
            s = entry_slot(cur, va, (lvl == 0) ? SHIFT_PML4 : SHIFT_PDPT);
            if ((pt_mem[s] & FLAG_PRESENT) == '0) begin
                if (!grab_page(nxt)) begin
                    pt_mem[s] = '0;
                    return ST_OOM;
                end
                pt_mem[s] = page_frame(nxt);
            end else if (!frame_to_page(pt_mem[s], nxt)) begin
                return ST_OOM;
            end
            pt_mem[s] |= LINK_FLAGS;
            cur = nxt;
        end
        pt_mem[entry_slot(cur, va, SHIFT_PD)] = {12'h0, pa} | LEAF_FLAGS;
        return ST_OK;
    endfunction

    function automatic walk_rsp_t translate_va(logic [VA_W-1:0] va);
        walk_rsp_t r;
        int unsigned cur;
        logic [ENTRY_W-1:0] e;
        int lvl;
        r.status = ST_UNMAPPED;
        r.entry = '0;
        if (!root_ok)
            return r;
        cur = root_pg;
        for (lvl = 0; lvl < 2; lvl++) begin
            e = pt_mem[entry_slot(cur, va, (lvl == 0) ? SHIFT_PML4 : SHIFT_PDPT)];
            if ((e & FLAG_PRESENT) == '0 || !frame_to_page(e, cur))
                return r;
        end
        e = pt_mem[entry_slot(cur, va, SHIFT_PD)];
        if ((e & FLAG_PRESENT) == '0)
            return r;
        r.status = ST_OK;
        r.entry = e & ~OFF_MASK;
        return r;
    endfunction

    function automatic walk_rsp_t walk_step(walk_req_t req);
        walk_rsp_t r;
        if (req.op == OP_MAP) begin
            r.status = map_leaf(req.va, req.pa);
            r.entry = '0;
        end else begin
            r = translate_va(req.va);
        end
        return r;
    endfunction

    // ---- driver and monitor ----
    walk_req_t queued_reqs [$];
    walk_rsp_t predicted_rsps [$];
    int gap_pct = 30;
    int in_flight = 0;
    int n_err = 0;
    int n_map = 0;
    int n_xlate = 0;
    int n_checked = 0;
    int n_bases = 0;
    int n_by_status [4] = '{0, 0, 0, 0};

    always @(posedge aclk) begin : drv
        walk_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req.op = s_opcode;
                req.va = s_virt_addr;
                req.pa = s_phys_addr;
                predicted_rsps.push_back(walk_step(req));
                if (s_opcode == OP_MAP)
                    n_map++;
                else
                    n_xlate++;
            end
            if (!s_valid || s_ready) begin
                if (queued_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    req = queued_reqs.pop_front();
                    in_flight++;
                    s_valid <= 1'b1;
                    s_opcode <= req.op;
                    s_virt_addr <= req.va;
                    s_phys_addr <= req.pa;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : mon
        walk_rsp_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_rsps.size() == 0) begin
                    $error("result with no item outstanding: status %0d entry %h",
                           m_status, m_translated_entry);
                    n_err++;
                end else begin
                    w = predicted_rsps.pop_front();
                    in_flight--;
                    n_checked++;
                    n_by_status[w.status]++;
                    if (m_status !== w.status) begin
                        $error("status: expected %0d, got %0d", w.status, m_status);
                        n_err++;
                    end
                    if (m_translated_entry !== w.entry) begin
                        $error("translated_entry: expected %h, got %h",
                               w.entry, m_translated_entry);
                        n_err++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // ---- stimulus ----
    bit               l4_taken [512];
    logic [IDX_W-1:0] live_l4 [2];
    logic [IDX_W-1:0] live_l3 [2][2];
    logic [IDX_W-1:0] dead_l4 [$];
    logic [VA_W-1:0]  mapped_va [$];

    function automatic logic [VA_W-1:0] pack_va(input logic [IDX_W-1:0] i4,
                                                input logic [IDX_W-1:0] i3,
                                                input logic [IDX_W-1:0] i2);
        return {i4, i3, i2, 21'($urandom)};
    endfunction

    function automatic logic [PA_W-1:0] rand_pa();
        return PA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IDX_W-1:0] fresh_l4();
        logic [IDX_W-1:0] i;
        do
            i = IDX_W'($urandom_range(511));
        while (l4_taken[i]);
        l4_taken[i] = 1'b1;
        return i;
    endfunction

    task automatic send_map(logic [VA_W-1:0] va, logic [PA_W-1:0] pa);
        walk_req_t req;
        req.op = OP_MAP;
        req.va = va;
        req.pa = pa;
        queued_reqs.push_back(req);
        mapped_va.push_back(va);
    endtask

    task automatic send_xlate(logic [VA_W-1:0] va);
        walk_req_t req;
        req.op = OP_XLATE;
        req.va = va;
        req.pa = rand_pa();
        queued_reqs.push_back(req);
    endtask

    task automatic wait_idle();
        while (queued_reqs.size() != 0 || in_flight != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_pool_base(logic [PA_W-1:0] b);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pool_base = b;
        n_bases++;
    endtask

    // after a base jump the old tree is unreachable; start two new top-level slots
    task automatic new_live_set();
        int j;
        for (j = 0; j < 2; j++) begin
            dead_l4.push_back(live_l4[j]);
            live_l4[j] = fresh_l4();
            live_l3[j][0] = IDX_W'($urandom);
            do
                live_l3[j][1] = IDX_W'($urandom);
            while (live_l3[j][1] == live_l3[j][0]);
            send_map(pack_va(live_l4[j], live_l3[j][0], IDX_W'($urandom)), rand_pa());
            send_map(pack_va(live_l4[j], live_l3[j][1], IDX_W'($urandom)), rand_pa());
        end
    endtask

    task automatic random_items(int n);
        int k;
        int r;
        int j;
        logic [VA_W-1:0] va;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            j = $urandom_range(1);
            if (r < 50) begin
                va = pack_va(live_l4[j], live_l3[j][$urandom_range(1)], IDX_W'($urandom));
                send_map(va, rand_pa());
            end else if (r < 58 && dead_l4.size() > 0) begin
                va = pack_va(dead_l4[$urandom_range(dead_l4.size() - 1)],
                             IDX_W'($urandom), IDX_W'($urandom));
                send_map(va, rand_pa());
            end else if (r < 85) begin
                va = mapped_va[$urandom_range(mapped_va.size() - 1)];
                va[20:0] = 21'($urandom);
                send_xlate(va);
            end else begin
                send_xlate(VA_W'({$urandom, $urandom}));
            end
        end
    endtask

    // run the pool dry so that the last page goes to a pointer table whose
    // directory can no longer be allocated, then try with no page at all
    task automatic drain_pool();
        int left;
        logic [IDX_W-1:0] i4;
        logic [IDX_W-1:0] i3;
        left = POOL_PAGES - free_pg;
        if (left % 2 == 0 && left > 0) begin
            do
                i3 = IDX_W'($urandom);
            while (i3 == live_l3[0][0] || i3 == live_l3[0][1]);
            send_map(pack_va(live_l4[0], i3, IDX_W'($urandom)), rand_pa());
            left--;
        end
        while (left > 1) begin
            send_map(pack_va(fresh_l4(), IDX_W'($urandom), IDX_W'($urandom)), rand_pa());
            left -= 2;
        end
        i4 = fresh_l4();
        i3 = IDX_W'($urandom);
        send_map(pack_va(i4, i3, IDX_W'($urandom)), rand_pa());
        send_xlate(pack_va(i4, i3, IDX_W'($urandom)));
        send_map(pack_va(i4, i3 ^ 9'd1, IDX_W'($urandom)), rand_pa());
        i4 = fresh_l4();
        send_map(pack_va(i4, IDX_W'($urandom), IDX_W'($urandom)), rand_pa());
        send_xlate(pack_va(i4, IDX_W'($urandom), IDX_W'($urandom)));
    endtask

    initial begin : stim
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        set_pool_base('0);

        send_xlate('0);
        send_xlate('1);
        send_map('0, '0);
        send_xlate('0);
        send_map('1, '1);
        send_xlate('1);
        send_xlate(pack_va(9'd0, 9'd1, 9'd0));
        send_xlate(pack_va(9'd0, 9'd0, 9'd1));
        send_map(pack_va(9'd0, 9'd0, 9'd0), 52'h8_0000_0123_4fff);
        send_xlate(pack_va(9'd0, 9'd0, 9'd0));
        send_xlate(pack_va(9'd5, 9'd0, 9'd0));
        send_map(pack_va(9'd511, 9'd511, 9'd0), 52'h5_5555_5555_5555);
        send_xlate(pack_va(9'd511, 9'd511, 9'd0));

        live_l4[0] = 9'd0;
        live_l4[1] = 9'd511;
        l4_taken[0] = 1'b1;
        l4_taken[511] = 1'b1;
        live_l3[0][0] = 9'd0;
        live_l3[0][1] = IDX_W'($urandom_range(511, 1));
        live_l3[1][0] = 9'd511;
        live_l3[1][1] = IDX_W'($urandom_range(510));
        send_map(pack_va(live_l4[0], live_l3[0][1], IDX_W'($urandom)), rand_pa());
        send_map(pack_va(live_l4[1], live_l3[1][1], IDX_W'($urandom)), rand_pa());
        random_items(200);
        wait_idle();

        // only the low bits change, so the tree stays reachable; no stalls this phase
        set_pool_base({40'h0, 12'($urandom_range(4095, 1))});
        gap_pct = 0;
        random_items(200);
        wait_idle();
        gap_pct = 30;

        set_pool_base({8'($urandom_range(254, 1)), 32'($urandom), 12'($urandom)});
        new_live_set();
        random_items(200);
        wait_idle();

        set_pool_base(BASE_TOP);
        new_live_set();
        random_items(200);
        wait_idle();

        drain_pool();
        random_items(60);
        wait_idle();

        $display("ran %0d maps and %0d translates over %0d pool base writes, pool pages used %0d",
                 n_map, n_xlate, n_bases, free_pg);
        $display("checked %0d results: %0d ok, %0d out of pages, %0d not mapped",
                 n_checked, n_by_status[ST_OK], n_by_status[ST_OOM],
                 n_by_status[ST_UNMAPPED]);
        if (n_err == 0)
            $display("page_table_map_and_walk test passed");
        else
            $display("page_table_map_and_walk test failed");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("page_table_map_and_walk test failed");
        $finish;
    end

endmodule
